// ===== src/frame_ring_buffer_drop_oldest_macros.svh =====
// Assertion macros for the frame ring buffer checker
`ifndef FRAME_RING_BUFFER_DROP_OLDEST_MACROS_SVH
`define FRAME_RING_BUFFER_DROP_OLDEST_MACROS_SVH

// same-cycle implication, disabled during reset
`define FRB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define FRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/frb_pkg.sv =====
// Types, codes and constants for the frame ring buffer
`timescale 1ns / 1ps
package frb_pkg;

  localparam int BUF_BYTES = 65536;
  localparam int ADDR_W    = $clog2(BUF_BYTES);
  localparam int HDR_BYTES = 16;
  localparam int RLEN_W    = 17;

  localparam logic [2:0] OP_PUT_FRAME = 3'd0;
  localparam logic [2:0] OP_PUT_BYTE  = 3'd1;
  localparam logic [2:0] OP_GET_FRAME = 3'd2;
  localparam logic [2:0] OP_GET_BYTE  = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;
  localparam logic [2:0] OP_DISCARD   = 3'd5;
  localparam logic [2:0] OP_DURATION  = 3'd6;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_EMPTY       = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE   = 3'd2;
  localparam logic [2:0] ST_READER_SMALL = 3'd3;
  localparam logic [2:0] ST_CORRUPT     = 3'd4;
  localparam logic [2:0] ST_BUSY        = 3'd5;
  localparam logic [2:0] ST_NOT_ENABLED = 3'd6;

  localparam logic [3:0] STREAM_VIDEO = 4'd1;
  localparam logic [3:0] FRAME_I      = 4'd1;

  localparam logic [3:0] HDR_RD_LAST = 4'd10;
  localparam logic [3:0] HDR_WR_LAST = 4'd15;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  data_byte;
    logic [15:0] frame_len;
    logic [3:0]  stream_type;
    logic [3:0]  frame_type;
    logic [47:0] timestamp;
    logic [15:0] reader_capacity;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  data_out;
    logic [3:0]  out_stream_type;
    logic [3:0]  out_frame_type;
    logic [47:0] out_timestamp;
    logic [15:0] out_frame_len;
    logic        last_byte;
    logic [16:0] free_bytes;
    logic [47:0] duration;
  } out_item_t;

  typedef enum logic [3:0] {
    CM_NONE,
    CM_LOAD,
    CM_SET_STATUS,
    CM_PUT_BYTE,
    CM_GB_ISSUE,
    CM_GB_CAPTURE,
    CM_CLEAR,
    CM_WALK_INIT,
    CM_HDR_READ,
    CM_EVICT_STEP,
    CM_HDR_WRITE,
    CM_GET_FRAME,
    CM_WALK_STEP,
    CM_POST
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t  code;
    logic [2:0] stat;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       en;
    logic       wr_busy;
    logic       rd_busy;
    logic       empty;
    logic       too_large;
    logic       need_evict;
    logic       hdr_done;
    logic       hwr_last;
    logic       corrupt;
    logic       evict_done;
    logic       walk_last;
    logic       slot_free;
  } dp_sts_t;

endpackage

// ===== src/frame_ring_buffer_drop_oldest.sv =====
// Top level of the frame ring buffer: register port, controller and datapath
//
//  channel | signals                       | transfer when
//  in      | in_valid/in_ready, in_data    | in_valid & in_ready
//  out     | out_valid/out_ready, out_data | out_valid & out_ready
//  cfg     | psel/penable/pwrite/paddr/... | psel & penable & pwrite (pready high)
//
// One operation at a time; get_byte adds a capture state for the registered store read.
// put_frame writes the 16-byte header through the single store write port, after
// evicting the oldest frames as needed; get_frame reads one header, discard and duration
// one per frame visited, each read one byte a cycle through the store read port.
// Reset empties the ring at once; the store itself is not cleared. A stalled result
// holds the output register; the next result is not posted until it drains.
`timescale 1ns / 1ps
module frame_ring_buffer_drop_oldest (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  frb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output frb_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import frb_pkg::*;

  logic        enable_r, enable_nxt;
  logic [16:0] buf_len_r, buf_len_nxt;
  logic [16:0] ring_len;
  logic        cfg_wr, cfg_clr;
  ctl_cmd_t    cmd;
  dp_sts_t     sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    enable_nxt  = enable_r;
    buf_len_nxt = buf_len_r;
    cfg_clr     = 1'b0;
    if (cfg_wr) begin
      if (paddr[2]) begin
        buf_len_nxt = pwdata[16:0];
        cfg_clr     = 1'b1;
      end else begin
        enable_nxt = pwdata[0];
        cfg_clr    = !pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      buf_len_r <= 17'(BUF_BYTES);
    end else begin
      enable_r  <= enable_nxt;
      buf_len_r <= buf_len_nxt;
    end
  end

  always_comb begin
    if (buf_len_r < 17'd64) begin
      ring_len = 17'd64;
    end else if (buf_len_r > 17'(BUF_BYTES)) begin
      ring_len = 17'(BUF_BYTES);
    end else begin
      ring_len = buf_len_r;
    end
  end

  assign prdata = paddr[2] ? {15'b0, buf_len_r} : {31'b0, enable_r};

  frb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  frb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_clr   (cfg_clr),
    .en        (enable_r),
    .ring_len  (ring_len),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

// ===== src/frb_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module frb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/frb_dp.sv =====
// Datapath: pointers, header registers, walk registers, store and result register
`timescale 1ns / 1ps
module frb_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  frb_pkg::ctl_cmd_t  cmd,
  output frb_pkg::dp_sts_t   sts,
  input  logic               cfg_clr,
  input  logic               en,
  input  logic [16:0]        ring_len,
  input  frb_pkg::in_item_t  in_data,
  output frb_pkg::out_item_t out_data,
  output logic               out_valid,
  input  logic               out_ready
);
  import frb_pkg::*;

  in_item_t    item_r, item_nxt;
  out_item_t   res_r, res_nxt, out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] rd_ptr_r, rd_ptr_nxt, wr_ptr_r, wr_ptr_nxt;
  logic        full_r, full_nxt;
  logic [15:0] wr_rem_r, wr_rem_nxt, rd_rem_r, rd_rem_nxt;
  logic [15:0] pos_r, pos_nxt, ipos_r, ipos_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [17:0] tf_r, tf_nxt, trav_r, trav_nxt;
  logic [15:0] h_len_r, h_len_nxt;
  logic [3:0]  h_st_r, h_st_nxt, h_ft_r, h_ft_nxt;
  logic [47:0] h_ts_r, h_ts_nxt;
  logic        have_i_r, have_i_nxt, have_v_r, have_v_nxt;
  logic [47:0] first_r, first_nxt, last_r, last_nxt;

  logic [16:0] free_sp, used, maxlen, need, step;
  logic [15:0] next_pos, hdr_addr, wr_inc, rd_inc, rd_hdr_skip;
  logic        corrupt, is_video, take, stop_now;
  logic [17:0] trav_sum;
  logic        have_i_n, have_v_n;
  logic [15:0] ipos_n;
  logic [47:0] first_n, last_n;
  logic [3:0]  rd_idx;
  logic        ram_we;
  logic [15:0] ram_raddr;
  logic [7:0]  ram_wdata, ram_q, hdr_wbyte;

  function automatic logic [15:0] wrap(input logic [17:0] s, input logic [16:0] l);
    logic [17:0] d;
    d = s - {1'b0, l};
    return (s >= {1'b0, l}) ? d[15:0] : s[15:0];
  endfunction

  always_comb begin
    if (wr_ptr_r > rd_ptr_r) begin
      free_sp = ring_len - {1'b0, wr_ptr_r} + {1'b0, rd_ptr_r};
    end else if (wr_ptr_r < rd_ptr_r) begin
      free_sp = {1'b0, rd_ptr_r} - {1'b0, wr_ptr_r};
    end else begin
      free_sp = full_r ? 17'd0 : ring_len;
    end
  end

  assign used        = ring_len - free_sp;
  assign maxlen      = ring_len - 17'(HDR_BYTES);
  assign need        = {1'b0, item_r.frame_len} + 17'(HDR_BYTES);
  assign step        = {1'b0, h_len_r} + 17'(HDR_BYTES);
  assign next_pos    = wrap({2'b0, pos_r} + {1'b0, step}, ring_len);
  assign hdr_addr    = wrap({2'b0, pos_r} + {14'b0, cnt_r}, ring_len);
  assign wr_inc      = wrap({2'b0, wr_ptr_r} + 18'd1, ring_len);
  assign rd_inc      = wrap({2'b0, rd_ptr_r} + 18'd1, ring_len);
  assign rd_hdr_skip = wrap({2'b0, rd_ptr_r} + 18'(HDR_BYTES), ring_len);
  assign corrupt     = {1'b0, h_len_r} > maxlen;
  assign is_video    = (h_st_r == STREAM_VIDEO);
  assign stop_now    = corrupt || (is_video && (item_r.op == OP_DISCARD) &&
                       (h_ts_r > item_r.timestamp));
  assign take        = !stop_now && is_video;
  assign trav_sum    = trav_r + {1'b0, step};
  assign rd_idx      = cnt_r - 4'd1;

  always_comb begin
    have_i_n = have_i_r;
    ipos_n   = ipos_r;
    have_v_n = have_v_r;
    first_n  = first_r;
    last_n   = last_r;
    if (take && (item_r.op == OP_DISCARD) && (h_ft_r == FRAME_I)) begin
      have_i_n = 1'b1;
      ipos_n   = pos_r;
    end
    if (take && (item_r.op == OP_DURATION)) begin
      if (!have_v_r) begin
        first_n = h_ts_r;
      end
      last_n   = h_ts_r;
      have_v_n = 1'b1;
    end
  end

  always_comb begin
    case (cnt_r)
      4'd0:    hdr_wbyte = item_r.frame_len[7:0];
      4'd1:    hdr_wbyte = item_r.frame_len[15:8];
      4'd2:    hdr_wbyte = {4'b0, item_r.stream_type};
      4'd3:    hdr_wbyte = {4'b0, item_r.frame_type};
      4'd4:    hdr_wbyte = item_r.timestamp[7:0];
      4'd5:    hdr_wbyte = item_r.timestamp[15:8];
      4'd6:    hdr_wbyte = item_r.timestamp[23:16];
      4'd7:    hdr_wbyte = item_r.timestamp[31:24];
      4'd8:    hdr_wbyte = item_r.timestamp[39:32];
      4'd9:    hdr_wbyte = item_r.timestamp[47:40];
      default: hdr_wbyte = 8'd0;
    endcase
  end

  assign ram_we    = (cmd.code == CM_PUT_BYTE) || (cmd.code == CM_HDR_WRITE);
  assign ram_wdata = (cmd.code == CM_PUT_BYTE) ? item_r.data_byte : hdr_wbyte;
  assign ram_raddr = (cmd.code == CM_GB_ISSUE) ? rd_ptr_r : hdr_addr;

  frb_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_comb begin
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    full_nxt      = full_r;
    wr_rem_nxt    = wr_rem_r;
    rd_rem_nxt    = rd_rem_r;
    pos_nxt       = pos_r;
    ipos_nxt      = ipos_r;
    cnt_nxt       = cnt_r;
    tf_nxt        = tf_r;
    trav_nxt      = trav_r;
    h_len_nxt     = h_len_r;
    h_st_nxt      = h_st_r;
    h_ft_nxt      = h_ft_r;
    h_ts_nxt      = h_ts_r;
    have_i_nxt    = have_i_r;
    have_v_nxt    = have_v_r;
    first_nxt     = first_r;
    last_nxt      = last_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (cmd.code)
      CM_LOAD: begin
        item_nxt = in_data;
        res_nxt  = '0;
        cnt_nxt  = 4'd0;
      end
      CM_SET_STATUS: res_nxt.status = cmd.stat;
      CM_PUT_BYTE: begin
        wr_ptr_nxt = wr_inc;
        wr_rem_nxt = wr_rem_r - 16'd1;
        if (wr_rem_r == 16'd1 && wr_inc == rd_ptr_r) begin
          full_nxt = 1'b1;
        end
      end
      CM_GB_ISSUE: begin
        rd_ptr_nxt        = rd_inc;
        rd_rem_nxt        = rd_rem_r - 16'd1;
        res_nxt.last_byte = (rd_rem_r == 16'd1);
      end
      CM_GB_CAPTURE: res_nxt.data_out = ram_q;
      CM_CLEAR: begin
        rd_ptr_nxt = '0;
        wr_ptr_nxt = '0;
        full_nxt   = 1'b0;
        wr_rem_nxt = '0;
        rd_rem_nxt = '0;
        cnt_nxt    = 4'd0;
      end
      CM_WALK_INIT: begin
        pos_nxt    = rd_ptr_r;
        tf_nxt     = {1'b0, free_sp};
        trav_nxt   = '0;
        have_i_nxt = 1'b0;
        have_v_nxt = 1'b0;
        first_nxt  = '0;
        last_nxt   = '0;
        cnt_nxt    = 4'd0;
      end
      CM_HDR_READ: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r != 4'd0) begin
          case (rd_idx)
            4'd0:    h_len_nxt[7:0]   = ram_q;
            4'd1:    h_len_nxt[15:8]  = ram_q;
            4'd2:    h_st_nxt         = ram_q[3:0];
            4'd3:    h_ft_nxt         = ram_q[3:0];
            4'd4:    h_ts_nxt[7:0]    = ram_q;
            4'd5:    h_ts_nxt[15:8]   = ram_q;
            4'd6:    h_ts_nxt[23:16]  = ram_q;
            4'd7:    h_ts_nxt[31:24]  = ram_q;
            4'd8:    h_ts_nxt[39:32]  = ram_q;
            4'd9:    h_ts_nxt[47:40]  = ram_q;
            default: h_ts_nxt         = h_ts_r;
          endcase
        end
      end
      CM_EVICT_STEP: begin
        tf_nxt  = tf_r + {1'b0, step};
        pos_nxt = next_pos;
        cnt_nxt = 4'd0;
        if (sts.evict_done) begin
          rd_ptr_nxt = next_pos;
          full_nxt   = 1'b0;
        end
      end
      CM_HDR_WRITE: begin
        wr_ptr_nxt = wr_inc;
        cnt_nxt    = cnt_r + 4'd1;
        if (cnt_r == HDR_WR_LAST) begin
          wr_rem_nxt = item_r.frame_len;
          if (item_r.frame_len == 16'd0 && wr_inc == rd_ptr_r) begin
            full_nxt = 1'b1;
          end
        end
      end
      CM_GET_FRAME: begin
        res_nxt.out_stream_type = h_st_r;
        res_nxt.out_frame_type  = h_ft_r;
        res_nxt.out_timestamp   = h_ts_r;
        res_nxt.out_frame_len   = h_len_r;
        if (h_len_r > item_r.reader_capacity) begin
          res_nxt.status = ST_READER_SMALL;
        end else if (corrupt) begin
          res_nxt.status = ST_CORRUPT;
          rd_ptr_nxt     = '0;
          wr_ptr_nxt     = '0;
          full_nxt       = 1'b0;
          wr_rem_nxt     = '0;
          rd_rem_nxt     = '0;
        end else begin
          rd_ptr_nxt = rd_hdr_skip;
          full_nxt   = 1'b0;
          rd_rem_nxt = h_len_r;
        end
      end
      CM_WALK_STEP: begin
        have_i_nxt = have_i_n;
        ipos_nxt   = ipos_n;
        have_v_nxt = have_v_n;
        first_nxt  = first_n;
        last_nxt   = last_n;
        trav_nxt   = trav_sum;
        pos_nxt    = next_pos;
        cnt_nxt    = 4'd0;
        if (sts.walk_last) begin
          if (item_r.op == OP_DISCARD) begin
            if (have_i_n && ipos_n != rd_ptr_r) begin
              rd_ptr_nxt = ipos_n;
              full_nxt   = 1'b0;
            end
          end else begin
            res_nxt.duration = last_n - first_n;
          end
        end
      end
      CM_POST: begin
        out_nxt            = res_r;
        out_nxt.free_bytes = en ? free_sp : 17'd0;
        out_valid_nxt      = 1'b1;
      end
      default: item_nxt = item_r;
    endcase

    if (cfg_clr) begin
      rd_ptr_nxt = '0;
      wr_ptr_nxt = '0;
      full_nxt   = 1'b0;
      wr_rem_nxt = '0;
      rd_rem_nxt = '0;
    end
  end

  always_comb begin
    sts.op         = item_r.op;
    sts.en         = en;
    sts.wr_busy    = (wr_rem_r != 16'd0);
    sts.rd_busy    = (rd_rem_r != 16'd0);
    sts.empty      = !full_r && (rd_ptr_r == wr_ptr_r);
    sts.too_large  = need > ring_len;
    sts.need_evict = need > free_sp;
    sts.hdr_done   = (cnt_r == HDR_RD_LAST);
    sts.hwr_last   = (cnt_r == HDR_WR_LAST);
    sts.corrupt    = corrupt;
    sts.evict_done = (tf_r + {1'b0, step}) >= {1'b0, need};
    sts.walk_last  = stop_now || (trav_sum >= {1'b0, used});
    sts.slot_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      full_r      <= 1'b0;
      wr_rem_r    <= '0;
      rd_rem_r    <= '0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      full_r      <= full_nxt;
      wr_rem_r    <= wr_rem_nxt;
      rd_rem_r    <= rd_rem_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
    pos_r    <= pos_nxt;
    ipos_r   <= ipos_nxt;
    tf_r     <= tf_nxt;
    trav_r   <= trav_nxt;
    h_len_r  <= h_len_nxt;
    h_st_r   <= h_st_nxt;
    h_ft_r   <= h_ft_nxt;
    h_ts_r   <= h_ts_nxt;
    have_i_r <= have_i_nxt;
    have_v_r <= have_v_nxt;
    first_r  <= first_nxt;
    last_r   <= last_nxt;
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule

// ===== src/frb_ctrl.sv =====
// Controller state machine: sequences datapath commands for each operation
`timescale 1ns / 1ps
module frb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  frb_pkg::dp_sts_t  sts,
  output frb_pkg::ctl_cmd_t cmd
);
  import frb_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EXEC = 7'b0000010,
    S_HRD  = 7'b0000100,
    S_EVAL = 7'b0001000,
    S_HWR  = 7'b0010000,
    S_GBW  = 7'b0100000,
    S_POST = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.code  = CM_NONE;
    cmd.stat  = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.code  = CM_LOAD;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_POST;
        if (!sts.en) begin
          cmd.code = CM_SET_STATUS;
          cmd.stat = ST_NOT_ENABLED;
        end else if ((sts.wr_busy && sts.op != OP_PUT_BYTE) ||
                     (sts.rd_busy && sts.op != OP_GET_BYTE)) begin
          cmd.code = CM_SET_STATUS;
          cmd.stat = ST_BUSY;
        end else begin
          unique case (sts.op)
            OP_PUT_FRAME: begin
              if (sts.too_large) begin
                cmd.code = CM_SET_STATUS;
                cmd.stat = ST_TOO_LARGE;
              end else if (sts.need_evict) begin
                cmd.code  = CM_WALK_INIT;
                state_nxt = S_HRD;
              end else begin
                state_nxt = S_HWR;
              end
            end
            OP_PUT_BYTE: begin
              if (!sts.wr_busy) begin
                cmd.code = CM_SET_STATUS;
                cmd.stat = ST_EMPTY;
              end else begin
                cmd.code = CM_PUT_BYTE;
              end
            end
            OP_GET_BYTE: begin
              if (!sts.rd_busy) begin
                cmd.code = CM_SET_STATUS;
                cmd.stat = ST_EMPTY;
              end else begin
                cmd.code  = CM_GB_ISSUE;
                state_nxt = S_GBW;
              end
            end
            OP_CLEAR: cmd.code = CM_CLEAR;
            OP_GET_FRAME, OP_DISCARD, OP_DURATION: begin
              if (sts.empty) begin
                cmd.code = CM_SET_STATUS;
                cmd.stat = ST_EMPTY;
              end else begin
                cmd.code  = CM_WALK_INIT;
                state_nxt = S_HRD;
              end
            end
            default: cmd.code = CM_NONE;
          endcase
        end
      end
      S_HRD: begin
        cmd.code = CM_HDR_READ;
        if (sts.hdr_done) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        unique case (sts.op)
          OP_PUT_FRAME: begin
            if (sts.corrupt) begin
              cmd.code  = CM_CLEAR;
              state_nxt = S_HWR;
            end else begin
              cmd.code  = CM_EVICT_STEP;
              state_nxt = sts.evict_done ? S_HWR : S_HRD;
            end
          end
          OP_GET_FRAME: begin
            cmd.code  = CM_GET_FRAME;
            state_nxt = S_POST;
          end
          default: begin
            cmd.code  = CM_WALK_STEP;
            state_nxt = sts.walk_last ? S_POST : S_HRD;
          end
        endcase
      end
      S_HWR: begin
        cmd.code = CM_HDR_WRITE;
        if (sts.hwr_last) begin
          state_nxt = S_POST;
        end
      end
      S_GBW: begin
        cmd.code  = CM_GB_CAPTURE;
        state_nxt = S_POST;
      end
      S_POST: begin
        if (sts.slot_free) begin
          cmd.code  = CM_POST;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// ===== src/frb_checker.sv =====
// Port-level checker for the frame ring buffer, bound to the top level
`timescale 1ns / 1ps
`include "frame_ring_buffer_drop_oldest_macros.svh"
module frb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input frb_pkg::out_item_t out_data,
  input logic               pready
);
  import frb_pkg::*;

  `FRB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  `FRB_ASSERT_NOW(a_disabled_free, out_valid && out_data.status == ST_NOT_ENABLED, out_data.free_bytes == 17'd0, "disabled result reports free space")
  `FRB_ASSERT_NOW(a_last_ok, out_valid && out_data.last_byte, out_data.status == ST_OK, "last byte flagged on failed transfer")
  `FRB_ASSERT_NOW(a_free_range, out_valid, out_data.free_bytes <= 17'(BUF_BYTES), "free space above store size")
  `FRB_ASSERT_NOW(a_pready, 1'b1, pready, "register port not ready")

endmodule

bind frame_ring_buffer_drop_oldest frb_checker u_frb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);
